// ===== design/tstl_pkg.sv =====
package tstl_pkg;

  localparam int INDEX_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH        = 2;
  localparam int FIELD_BITS         = 32;
  localparam int CFG_INDEX_BITS     = 2;
  localparam logic [FIELD_BITS-1:0] RESTART_INDEX = 32'h0000_FFFF;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_STRIP_MODE      = 2'd0,
    CFG_DROP_DEGENERATE = 2'd1,
    CFG_NARROW_INDICES  = 2'd2
  } cfg_index_t;

  typedef enum logic {
    JOB_SINGLE   = 1'b0,
    JOB_TRIANGLE = 1'b1
  } job_kind_t;

  typedef struct packed {
    logic strip_mode;
    logic drop_degenerate;
    logic narrow_indices;
  } cfg_t;

endpackage

// ===== design/tstl_front.sv =====
module tstl_front #(
  parameter int INDEX_BITS = tstl_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tstl_pkg::cfg_t                       cfg,
  input  logic                                 in_fire,
  input  logic [tstl_pkg::FIELD_BITS-1:0]      in_index,
  input  logic                                 in_starts_set,
  output logic                                 push_valid,
  output logic [3*INDEX_BITS:0]                push_data
);
  import tstl_pkg::*;

  localparam logic [FIELD_BITS-1:0] INDEX_MASK =
    FIELD_BITS'((64'd1 << INDEX_BITS) - 64'd1);

  logic [INDEX_BITS-1:0] older_r, older_nxt;
  logic [INDEX_BITS-1:0] newer_r, newer_nxt;
  logic [1:0]            fill_r, fill_nxt;
  logic                  odd_r, odd_nxt;

  logic [FIELD_BITS-1:0] v32;
  logic [INDEX_BITS-1:0] v;
  logic [1:0]            fill_eff;
  logic                  odd_eff;
  logic                  degenerate;

  assign v32 = in_index & INDEX_MASK;
  assign v   = v32[INDEX_BITS-1:0];

  always_comb begin
    fill_eff   = in_starts_set ? 2'd0 : fill_r;
    odd_eff    = in_starts_set ? 1'b0 : odd_r;
    degenerate = (older_r == newer_r) || (newer_r == v) || (v == older_r);
    older_nxt  = older_r;
    newer_nxt  = newer_r;
    fill_nxt   = fill_r;
    odd_nxt    = odd_r;
    push_valid = 1'b0;
    push_data  = {{(2*INDEX_BITS){1'b0}}, v, JOB_SINGLE};
    if (in_fire) begin
      fill_nxt = fill_eff;
      odd_nxt  = odd_eff;
      if (!cfg.strip_mode) begin
        push_valid = 1'b1;
      end else if (cfg.narrow_indices && (v32 == RESTART_INDEX)) begin
        fill_nxt = 2'd0;
        odd_nxt  = 1'b0;
      end else if (fill_eff < 2'd2) begin
        older_nxt = newer_r;
        newer_nxt = v;
        fill_nxt  = fill_eff + 2'd1;
      end else begin
        push_valid = !(cfg.drop_degenerate && degenerate);
        // Odd triangles swap the first two corners to keep the winding.
        if (odd_eff) begin
          push_data = {v, older_r, newer_r, JOB_TRIANGLE};
        end else begin
          push_data = {v, newer_r, older_r, JOB_TRIANGLE};
        end
        older_nxt = newer_r;
        newer_nxt = v;
        odd_nxt   = ~odd_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= '0;
      newer_r <= '0;
      fill_r  <= 2'd0;
      odd_r   <= 1'b0;
    end else begin
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      fill_r  <= fill_nxt;
      odd_r   <= odd_nxt;
    end
  end

endmodule

// ===== design/tstl_queue.sv =====
module tstl_queue #(
  parameter int WIDTH = 3 * tstl_pkg::INDEX_BITS_DEFAULT + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data,
  input  logic             pop
);
  import tstl_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  logic [WIDTH-1:0] entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/tstl_back.sv =====
module tstl_back #(
  parameter int INDEX_BITS = tstl_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             head_valid,
  input  logic [3*INDEX_BITS:0]            head_data,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tstl_pkg::FIELD_BITS-1:0]  out_tdata,
  output logic                             out_tlast
);
  import tstl_pkg::*;

  logic [1:0]            phase_r, phase_nxt;
  logic                  valid_r, valid_nxt;
  logic [FIELD_BITS-1:0] data_r;
  logic                  last_r;
  logic                  load;
  logic                  last_sel;
  logic [INDEX_BITS-1:0] corner_sel;
  job_kind_t             kind;

  assign kind = job_kind_t'(head_data[0]);
  assign load = head_valid && (!valid_r || out_tready);
  assign pop  = load && last_sel;

  always_comb begin
    case (phase_r)
      2'd0:    corner_sel = head_data[INDEX_BITS:1];
      2'd1:    corner_sel = head_data[2*INDEX_BITS:INDEX_BITS+1];
      default: corner_sel = head_data[3*INDEX_BITS:2*INDEX_BITS+1];
    endcase
    last_sel  = (kind == JOB_SINGLE) || (phase_r == 2'd2);
    phase_nxt = phase_r;
    valid_nxt = out_tready ? 1'b0 : valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      phase_nxt = last_sel ? 2'd0 : phase_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= FIELD_BITS'(corner_sel);
      last_r <= last_sel;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

// ===== design/triangle_strip_to_list_unit.sv =====
// Channel  Direction  Handshake              Payload
// in_      slave      in_tvalid / in_tready  tdata: vertex_index; tuser: starts_set
// out_     master     out_tvalid/out_tready  tdata: out_vertex; tlast: triangle_done
// cfg_     write      cfg_we                 cfg_index selects register, cfg_wdata bit 0
//
// List mode moves one index per cycle while the job queue is not full. In strip
// mode the serializer sends each triangle's corners one per transfer on the result
// channel; indices that emit nothing are absorbed at one per cycle unless the queue is full.
// A two-entry job queue lets the input keep transferring while corners drain.
// Synchronous active-low reset clears the strip state, queue and registers.
module triangle_strip_to_list_unit #(
  parameter int INDEX_BITS = tstl_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tstl_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic                                 cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tstl_pkg::FIELD_BITS-1:0]      in_tdata,   // [31:0] vertex_index
  input  logic                                 in_tuser,   // [0] starts_set
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tstl_pkg::FIELD_BITS-1:0]      out_tdata,  // [31:0] out_vertex
  output logic                                 out_tlast
);
  import tstl_pkg::*;

  localparam int JOB_W = 3 * INDEX_BITS + 1;

  cfg_t             cfg_r, cfg_nxt;
  logic             in_fire;
  logic             push_valid;
  logic [JOB_W-1:0] push_data;
  logic             queue_full;
  logic             head_valid;
  logic [JOB_W-1:0] head_data;
  logic             pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_STRIP_MODE:      cfg_nxt.strip_mode      = cfg_wdata;
        CFG_DROP_DEGENERATE: cfg_nxt.drop_degenerate = cfg_wdata;
        CFG_NARROW_INDICES:  cfg_nxt.narrow_indices  = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = !queue_full;
  assign in_fire   = in_tvalid && in_tready;

  tstl_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_fire       (in_fire),
    .in_index      (in_tdata),
    .in_starts_set (in_tuser),
    .push_valid    (push_valid),
    .push_data     (push_data)
  );

  tstl_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_data  (push_data),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  tstl_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
